// ===== hw/rtl/arlc_pkg.sv =====
// Shared types and constants of the account risk limit checker.
package arlc_pkg;
   localparam int NUM_SLOTS_DEF = 16;
   localparam int MW = 48;

   localparam logic [2:0] CMD_ADD    = 3'd0;
   localparam logic [2:0] CMD_REMOVE = 3'd1;
   localparam logic [2:0] CMD_UPDATE = 3'd2;
   localparam logic [2:0] CMD_CHECK  = 3'd3;
   localparam logic [2:0] CMD_KILLON = 3'd4;
   localparam logic [2:0] CMD_KILLOF = 3'd5;
   localparam logic [2:0] CMD_QUERY  = 3'd6;

   localparam logic [2:0] RC_PASS     = 3'd0;
   localparam logic [2:0] RC_NOTFOUND = 3'd1;
   localparam logic [2:0] RC_KILL     = 3'd2;
   localparam logic [2:0] RC_EXPOSURE = 3'd3;
   localparam logic [2:0] RC_LOSS     = 3'd4;
   localparam logic [2:0] RC_POS      = 3'd5;

   // Stored record of one account (kept in memory).
   typedef struct packed {
      logic [31:0]        key;
      logic signed [47:0] max_exp;
      logic signed [47:0] loss_lim;
      logic [15:0]        max_pos;
      logic signed [47:0] exposure;
      logic signed [47:0] pnl;
      logic [15:0]        positions;
      logic               risk;
   } rec_type;

   // Request from the sequencer to the shared compare unit.
   typedef struct packed {
      logic signed [48:0] a;
      logic signed [48:0] b;
   } cmp_req_type;
endpackage

// ===== hw/rtl/arlc_cmp.sv =====
// Shared 49-bit signed subtract-and-compare unit with registered result.
module arlc_cmp
   import arlc_pkg::*;
(
   input  logic        clock,
   input  arlc_pkg::cmp_req_type req,
   output logic        gt_ff
);
   logic signed [49:0] diff;
   // Compare a against b at 50 bits.
   assign diff = {req.a[48], req.a} - {req.b[48], req.b};
   always_ff @(posedge clock) begin
      gt_ff <= !diff[49] && (diff != '0);
   end
endmodule

// ===== hw/rtl/account_risk_limit_checker_core.sv =====
// Account risk limit checker: sequential table walk with one shared comparator.
// Each command takes one word and returns one word. The block scans the slot
// table one entry per cycle from memory (one scan serves both the key search
// and the free-slot search), then reads the record, runs the limit compares
// through the single comparator in S_C1, S_C2 and S_C3, writes back in S_DONE
// and holds the response in S_RESP until it is taken, then returns to idle.
// req_stall stays high from acceptance until the response is taken. Used and
// kill bits live in flip-flops cleared by reset; record memory holds garbage
// until written by an add.
module account_risk_limit_checker_core
   import arlc_pkg::*;
#(
   parameter int NUM_SLOTS = NUM_SLOTS_DEF
)(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [2:0]         req_cmd,
   input  logic [31:0]        req_account_key,
   input  logic               req_all_accounts,
   input  logic signed [47:0] req_limit_exposure,
   input  logic signed [47:0] req_limit_loss,
   input  logic [15:0]        req_limit_positions,
   input  logic signed [47:0] req_new_exposure,
   input  logic signed [47:0] req_new_pnl,
   input  logic [15:0]        req_new_positions,
   input  logic signed [47:0] req_order_amount,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_ok,
   output logic [2:0]         rsp_reason_code,
   output logic signed [48:0] rsp_current_amount,
   output logic signed [47:0] rsp_limit_amount,
   output logic               rsp_at_risk,
   output logic signed [47:0] rsp_exposure_out,
   output logic               rsp_kill_active
);
   localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int CW = $clog2(NUM_SLOTS + 1);

   typedef enum logic [7:0] {
      S_IDLE  = 8'b00000001,
      S_SCAN  = 8'b00000010,
      S_READ  = 8'b00000100,
      S_C1    = 8'b00001000,
      S_C2    = 8'b00010000,
      S_C3    = 8'b00100000,
      S_DONE  = 8'b01000000,
      S_RESP  = 8'b10000000
   } state_type;

   state_type state_ff, state_in;
   rec_type mem [NUM_SLOTS];
   rec_type rd_ff, wr_rec;
   logic wr_en;
   logic [IW-1:0] wr_addr, rd_addr;
   logic [NUM_SLOTS-1:0] used_ff, used_in, kill_ff, kill_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [IW-1:0] hit_ff, hit_in, free_ff, free_in;
   logic found_ff, found_in, hasfree_ff, hasfree_in;
   logic [2:0] cmd_ff;
   logic [31:0] key_ff;
   logic all_ff;
   logic signed [47:0] la_ff, ll_ff, ne_ff, np_ff, oa_ff;
   logic [15:0] lp_ff, npos_ff;
   cmp_req_type creq;
   logic gt;
   logic flag_ff, flag_in;
   logic ok_in, at_in, kq_in;
   logic [2:0] rc_in;
   logic signed [48:0] cur_in;
   logic signed [47:0] lim_in, ex_in;
   logic scan_vld_ff;
   logic [IW-1:0] scan_idx_ff;
   logic exp_flag_ff, loss_flag_ff;

   arlc_cmp u_cmp (.clock(clock), .req(creq), .gt_ff(gt));

   assign req_stall = (state_ff != S_IDLE);
   assign rd_addr = (state_ff == S_SCAN) ? cnt_ff[IW-1:0] : hit_ff;

   // Record memory: one write, one registered read.
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_rec;
      rd_ff <= mem[rd_addr];
   end

   // Capture the request word.
   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && req_valid) begin
         cmd_ff <= req_cmd; key_ff <= req_account_key; all_ff <= req_all_accounts;
         la_ff <= req_limit_exposure; ll_ff <= req_limit_loss;
         lp_ff <= req_limit_positions; ne_ff <= req_new_exposure;
         np_ff <= req_new_pnl; npos_ff <= req_new_positions;
         oa_ff <= req_order_amount;
      end
   end

   // Drive the shared comparator per step, once the hit record is in rd_ff.
   always_comb begin
      creq.a = '0; creq.b = '0;
      case (state_ff)
         S_C1: begin
            if (cmd_ff == CMD_UPDATE) begin
               creq.a = 49'(ne_ff); creq.b = 49'(rd_ff.max_exp);
            end else begin
               creq.a = 49'(rd_ff.exposure) + 49'(oa_ff); creq.b = 49'(rd_ff.max_exp);
            end
         end
         S_C2: begin
            if (cmd_ff == CMD_UPDATE) begin
               creq.a = -49'(rd_ff.loss_lim); creq.b = 49'(np_ff);
            end else begin
               creq.a = -49'(rd_ff.loss_lim); creq.b = 49'(rd_ff.pnl);
            end
         end
         S_C3: begin
            creq.a = 49'(rd_ff.max_pos); creq.b = 49'(rd_ff.positions);
         end
         default: ;
      endcase
   end

   // Sequencer and result formation.
   always_comb begin
      state_in = state_ff; cnt_in = cnt_ff; hit_in = hit_ff; free_in = free_ff;
      found_in = found_ff; hasfree_in = hasfree_ff; flag_in = flag_ff;
      used_in = used_ff; kill_in = kill_ff;
      wr_en = 1'b0; wr_addr = hit_ff; wr_rec = rd_ff;
      ok_in = 1'b0; rc_in = RC_PASS; cur_in = '0; lim_in = '0; at_in = 1'b0;
      ex_in = '0; kq_in = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_SCAN; cnt_in = '0; found_in = 1'b0; hasfree_in = 1'b0;
            end
         end
         S_SCAN: begin
            // check the entry read last cycle
            if (scan_vld_ff) begin
               if (used_ff[scan_idx_ff] && rd_ff.key == key_ff && !found_ff) begin
                  found_in = 1'b1; hit_in = scan_idx_ff;
               end
               if (!used_ff[scan_idx_ff] && !hasfree_ff) begin
                  hasfree_in = 1'b1; free_in = scan_idx_ff;
               end
            end
            if (cnt_ff != CW'(NUM_SLOTS)) cnt_in = cnt_ff + 1'b1;
            else state_in = S_READ;
         end
         S_READ: state_in = S_C1;
         S_C1: state_in = S_C2;
         S_C2: begin flag_in = gt; state_in = S_C3; end
         S_C3: begin flag_in = flag_ff | gt; state_in = S_DONE; end
         S_DONE: begin
            state_in = S_RESP;
            case (cmd_ff)
               CMD_ADD: begin
                  if (!found_ff && hasfree_ff) begin
                     wr_en = 1'b1; wr_addr = free_ff;
                     wr_rec.key = key_ff; wr_rec.max_exp = la_ff;
                     wr_rec.loss_lim = ll_ff; wr_rec.max_pos = lp_ff;
                     wr_rec.exposure = '0; wr_rec.pnl = '0; wr_rec.positions = '0;
                     wr_rec.risk = 1'b0;
                     used_in[free_ff] = 1'b1; kill_in[free_ff] = 1'b0;
                     ok_in = 1'b1;
                  end
               end
               CMD_REMOVE: begin
                  if (!found_ff) rc_in = RC_NOTFOUND;
                  else begin used_in[hit_ff] = 1'b0; ok_in = 1'b1; end
               end
               CMD_UPDATE: begin
                  if (!found_ff) rc_in = RC_NOTFOUND;
                  else begin
                     wr_en = 1'b1;
                     wr_rec.exposure = ne_ff; wr_rec.pnl = np_ff;
                     wr_rec.positions = npos_ff; wr_rec.risk = flag_ff;
                     ok_in = 1'b1;
                  end
               end
               CMD_CHECK: begin
                  // test in order: exposure, daily loss, positions (gt is max > pos)
                  if (!found_ff) rc_in = RC_NOTFOUND;
                  else if (kill_ff[hit_ff]) rc_in = RC_KILL;
                  else if (exp_flag_ff) begin
                     rc_in = RC_EXPOSURE;
                     cur_in = 49'(rd_ff.exposure) + 49'(oa_ff);
                     lim_in = rd_ff.max_exp;
                  end else if (loss_flag_ff) begin
                     rc_in = RC_LOSS; cur_in = -49'(rd_ff.pnl); lim_in = rd_ff.loss_lim;
                  end else if (!gt) begin
                     rc_in = RC_POS; cur_in = 49'(rd_ff.positions);
                     lim_in = 48'(rd_ff.max_pos);
                  end else ok_in = 1'b1;
               end
               CMD_KILLON, CMD_KILLOF: begin
                  if (all_ff) begin
                     kill_in = (cmd_ff == CMD_KILLON) ? (kill_ff | used_ff) : '0;
                     ok_in = 1'b1;
                  end else if (!found_ff) rc_in = RC_NOTFOUND;
                  else begin kill_in[hit_ff] = (cmd_ff == CMD_KILLON); ok_in = 1'b1; end
               end
               CMD_QUERY: begin
                  if (all_ff) begin kq_in = |(kill_ff & used_ff); ok_in = 1'b1; end
                  else if (!found_ff) rc_in = RC_NOTFOUND;
                  else begin
                     at_in = rd_ff.risk; ex_in = rd_ff.exposure;
                     kq_in = kill_ff[hit_ff]; ok_in = 1'b1;
                  end
               end
               default: ;
            endcase
         end
         S_RESP: if (!rsp_stall) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // Hold the exposure and loss results of the order check separately.
   always_ff @(posedge clock) begin
      if (state_ff == S_C2) exp_flag_ff <= gt;
      if (state_ff == S_C3) loss_flag_ff <= gt;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; used_ff <= '0; kill_ff <= '0; rsp_valid <= 1'b0;
         scan_vld_ff <= 1'b0;
      end else begin
         state_ff <= state_in; used_ff <= used_in; kill_ff <= kill_in;
         scan_vld_ff <= (state_ff == S_SCAN) && (cnt_ff != CW'(NUM_SLOTS));
         if (state_ff == S_DONE) rsp_valid <= 1'b1;
         else if (state_ff == S_RESP && !rsp_stall) rsp_valid <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in; hit_ff <= hit_in; free_ff <= free_in;
      found_ff <= found_in; hasfree_ff <= hasfree_in; flag_ff <= flag_in;
      scan_idx_ff <= cnt_ff[IW-1:0];
      if (state_ff == S_DONE) begin
         rsp_ok <= ok_in; rsp_reason_code <= rc_in;
         rsp_current_amount <= cur_in;
         rsp_limit_amount <= lim_in;
         rsp_at_risk <= at_in; rsp_exposure_out <= ex_in; rsp_kill_active <= kq_in;
      end
   end
endmodule

// ===== hw/rtl/arlc_checker.sv =====
// Port-level checker for the account risk limit checker, bound to the top level.
module arlc_checker
   import arlc_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic       rsp_ok,
   input logic [2:0] rsp_reason_code
);
   // One word in flight: no acceptance while a response waits.
   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall) else $error("accepted while response pending");
   // Success never carries a reason.
   a_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ok) |-> (rsp_reason_code == RC_PASS))
      else $error("ok with reason");
   // Reason codes stay in range.
   a_rc: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_reason_code <= RC_POS)) else $error("bad reason");
   // A response stalled stays valid.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid) else $error("response dropped");
endmodule

bind account_risk_limit_checker_core arlc_checker u_arlc_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_ok(rsp_ok),
   .rsp_reason_code(rsp_reason_code)
);
